/* src/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

/* src/mrpt_pkg.sv */
package mrpt_pkg;

  localparam int NumberWidth = 63;
  localparam int BaseTableSize = 12;
  localparam int NumBasesDefault = 10;

  typedef logic [NumberWidth-1:0] num_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_BASE,
    ST_POW_BIT,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_SQ_MUL,
    ST_SQ_CHECK,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    num_t x;
    num_t y;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    num_t product;
  } mul_rsp_t;

  function automatic logic [5:0] base_at(input logic [3:0] idx);
    logic [5:0] b;
    case (idx)
      4'd0: b = 6'd2;
      4'd1: b = 6'd3;
      4'd2: b = 6'd5;
      4'd3: b = 6'd7;
      4'd4: b = 6'd11;
      4'd5: b = 6'd13;
      4'd6: b = 6'd17;
      4'd7: b = 6'd19;
      4'd8: b = 6'd23;
      4'd9: b = 6'd29;
      4'd10: b = 6'd31;
      4'd11: b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

endpackage

/* src/mrpt_if.sv */
interface mrpt_in_if;
  logic valid;
  logic ready;
  logic [mrpt_pkg::NumberWidth-1:0] number;
  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface mrpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

/* src/mrpt_modmul.sv */
`include "assert_macros.svh"
// Shift-add modular multiplier: one bit of y per cycle, top bit first.
module mrpt_modmul (
  input  logic                clk,
  input  logic                rst_n,
  input  mrpt_pkg::num_t      modulus,
  input  mrpt_pkg::mul_req_t  req,
  output mrpt_pkg::mul_rsp_t  rsp
);
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [5:0] bit_r, bit_nxt;
  mrpt_pkg::num_t acc_r, acc_nxt;
  mrpt_pkg::num_t x_r, x_nxt;
  mrpt_pkg::num_t y_r, y_nxt;

  logic [63:0] dbl, dbl_red, add, add_red;

  always_comb begin
    dbl = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    add = dbl_red + {1'b0, x_r};
    add_red = (add >= {1'b0, modulus}) ? add - {1'b0, modulus} : add;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt = bit_r;
    acc_nxt = acc_r;
    x_nxt = x_r;
    y_nxt = y_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      bit_nxt = 6'd62;
      acc_nxt = '0;
      x_nxt = req.x;
      y_nxt = req.y;
    end else if (busy_r) begin
      acc_nxt = y_r[bit_r] ? add_red[62:0] : dbl_red[62:0];
      bit_nxt = bit_r - 6'd1;
      if (bit_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bit_r <= bit_nxt;
    end
    acc_r <= acc_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.product = acc_r;

  `ASSERT_NEVER(a_done_busy, done_r && busy_r, "modmul done while busy")
  `ASSERT_CLK(a_done_after_last, $rose(done_r) |-> $past(busy_r) && $past(bit_r) == 6'd0,
    "modmul done without last bit")
  `ASSERT_CLK(a_acc_below_mod, done_r |-> acc_r < modulus, "modmul result not reduced")
endmodule

/* src/miller_rabin_prime_test.sv */
// Miller-Rabin prime test over a 63-bit number with the first NUM_BASES primes.
// Input channel in_*: one request carries a number; it is taken when in_valid and
// in_ready are both high. in_ready is high only while the block is idle.
// Output channel out_*: one request per number, is_prime high if the number
// passes every base (exact for all 63-bit numbers with ten bases).
// The work is paced by the single shift-add modular multiplier, which forms one
// product at a time. Each base does one square per bit of d and one multiply
// per set bit of d, then s squarings. Small numbers, numbers equal to a base,
// and composites caught early finish much sooner than a large prime.
// One number is worked on at a time; the next is taken after its result leaves.
// The result waits in an output register until out_ready is high; while the
// receiver stalls, no new number is accepted.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; any number in progress is discarded.
`include "assert_macros.svh"
module miller_rabin_prime_test #(
  parameter int NUM_BASES = mrpt_pkg::NumBasesDefault
) (
  input logic clk,
  input logic rst_n,
  mrpt_in_if.sink in_ch,
  mrpt_out_if.source out_ch
);
  localparam int UsedBases = (NUM_BASES > mrpt_pkg::BaseTableSize) ?
                             mrpt_pkg::BaseTableSize : NUM_BASES;
  localparam logic [3:0] LastBase = 4'(UsedBases - 1);

  mrpt_pkg::state_t state_r, state_nxt;
  mrpt_pkg::num_t n_r, n_nxt;       // modulus
  mrpt_pkg::num_t d_r, d_nxt;       // odd part of n-1
  mrpt_pkg::num_t e_r, e_nxt;       // remaining exponent bits
  mrpt_pkg::num_t g_r, g_nxt;       // running power of base
  mrpt_pkg::num_t x_r, x_nxt;       // accumulator / squaring value
  logic [5:0] s_r, s_nxt;
  logic [5:0] j_r, j_nxt;
  logic [3:0] bi_r, bi_nxt;
  logic prime_r, prime_nxt;
  logic ovalid_r, ovalid_nxt;
  logic wait_r, wait_nxt;           // waiting for multiplier

  mrpt_pkg::mul_req_t mreq;
  mrpt_pkg::mul_rsp_t mrsp;

  mrpt_modmul u_mul (.clk(clk), .rst_n(rst_n), .modulus(n_r), .req(mreq), .rsp(mrsp));

  logic is_base;
  logic [5:0] base_cur;
  mrpt_pkg::num_t nm1;

  always_comb begin
    is_base = 1'b0;
    for (int i = 0; i < UsedBases; i++) begin
      if (n_r == mrpt_pkg::num_t'(mrpt_pkg::base_at(4'(i)))) is_base = 1'b1;
    end
    base_cur = mrpt_pkg::base_at(bi_r);
    nm1 = n_r - mrpt_pkg::num_t'(1);
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; d_nxt = d_r; e_nxt = e_r; g_nxt = g_r; x_nxt = x_r;
    s_nxt = s_r; j_nxt = j_r; bi_nxt = bi_r;
    prime_nxt = prime_r; ovalid_nxt = ovalid_r; wait_nxt = wait_r;
    mreq.start = 1'b0;
    mreq.x = x_r;
    mreq.y = x_r;
    case (state_r)
      mrpt_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          n_nxt = in_ch.number;
          state_nxt = mrpt_pkg::ST_CHECK;
        end
      end
      mrpt_pkg::ST_CHECK: begin
        if (n_r < mrpt_pkg::num_t'(2)) begin
          prime_nxt = 1'b0; state_nxt = mrpt_pkg::ST_DONE;
        end else if (is_base) begin
          prime_nxt = 1'b1; state_nxt = mrpt_pkg::ST_DONE;
        end else begin
          d_nxt = nm1; s_nxt = '0; bi_nxt = '0;
          state_nxt = mrpt_pkg::ST_SPLIT;
        end
      end
      mrpt_pkg::ST_SPLIT: begin
        if (!d_r[0] && s_r < 6'd63) begin
          d_nxt = d_r >> 1; s_nxt = s_r + 6'd1;
        end else begin
          state_nxt = mrpt_pkg::ST_BASE;
        end
      end
      mrpt_pkg::ST_BASE: begin
        // A number that reaches here below some base is composite and is
        // rejected by base two, so every base actually used is below n and
        // base mod n is the base itself.
        g_nxt = mrpt_pkg::num_t'(base_cur);
        x_nxt = mrpt_pkg::num_t'(1);
        e_nxt = d_r;
        state_nxt = mrpt_pkg::ST_POW_BIT;
      end
      mrpt_pkg::ST_POW_BIT: begin
        if (e_r == '0) begin
          j_nxt = '0;
          state_nxt = (s_r == '0) ? mrpt_pkg::ST_FINAL : mrpt_pkg::ST_SQ_MUL;
        end else if (e_r[0]) begin
          state_nxt = mrpt_pkg::ST_POW_MUL;
        end else begin
          state_nxt = mrpt_pkg::ST_POW_SQR;
        end
      end
      mrpt_pkg::ST_POW_MUL: begin
        mreq.x = x_r; mreq.y = g_r;
        if (!wait_r) begin
          mreq.start = 1'b1; wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          x_nxt = mrsp.product; wait_nxt = 1'b0;
          state_nxt = mrpt_pkg::ST_POW_SQR;
        end
      end
      mrpt_pkg::ST_POW_SQR: begin
        mreq.x = g_r; mreq.y = g_r;
        if (!wait_r) begin
          mreq.start = 1'b1; wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          g_nxt = mrsp.product; wait_nxt = 1'b0;
          e_nxt = e_r >> 1;
          state_nxt = mrpt_pkg::ST_POW_BIT;
        end
      end
      mrpt_pkg::ST_SQ_MUL: begin
        mreq.x = x_r; mreq.y = x_r;
        if (!wait_r) begin
          mreq.start = 1'b1; wait_nxt = 1'b1;
        end else if (mrsp.done) begin
          wait_nxt = 1'b0;
          g_nxt = mrsp.product;   // square held in g
          state_nxt = mrpt_pkg::ST_SQ_CHECK;
        end
      end
      mrpt_pkg::ST_SQ_CHECK: begin
        if (g_r == mrpt_pkg::num_t'(1) && x_r != mrpt_pkg::num_t'(1) && x_r != nm1) begin
          prime_nxt = 1'b0; state_nxt = mrpt_pkg::ST_DONE;
        end else begin
          x_nxt = g_r;
          j_nxt = j_r + 6'd1;
          state_nxt = (j_r + 6'd1 == s_r) ? mrpt_pkg::ST_FINAL : mrpt_pkg::ST_SQ_MUL;
        end
      end
      mrpt_pkg::ST_FINAL: begin
        if (x_r != mrpt_pkg::num_t'(1)) begin
          prime_nxt = 1'b0; state_nxt = mrpt_pkg::ST_DONE;
        end else if (bi_r == LastBase) begin
          prime_nxt = 1'b1; state_nxt = mrpt_pkg::ST_DONE;
        end else begin
          bi_nxt = bi_r + 4'd1;
          state_nxt = mrpt_pkg::ST_BASE;
        end
      end
      mrpt_pkg::ST_DONE: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
        end else if (out_ch.ready) begin
          ovalid_nxt = 1'b0;
          state_nxt = mrpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mrpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrpt_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      wait_r <= 1'b0;
      bi_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      wait_r <= wait_nxt;
      bi_r <= bi_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; e_r <= e_nxt; g_r <= g_nxt; x_r <= x_nxt;
    s_r <= s_nxt; j_r <= j_nxt; prime_r <= prime_nxt;
  end

  assign in_ch.ready = (state_r == mrpt_pkg::ST_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.is_prime = prime_r;

  `ASSERT_NEVER(a_busy_both, in_ch.ready && out_ch.valid, "input ready while result pending")
  `ASSERT_CLK(a_hold_result, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(prime_r),
    "result dropped or changed while stalled")
  `ASSERT_NEVER(a_base_range, bi_r > LastBase && state_r != mrpt_pkg::ST_IDLE
    && state_r != mrpt_pkg::ST_CHECK, "base index out of range")
  `ASSERT_CLK(a_wait_mul, wait_r && !mrsp.done |-> mrsp.busy || $past(mreq.start),
    "waiting on idle multiplier")
endmodule

/* tb/sv/mrpt_result_checker.sv */
`timescale 1ns / 100ps

module mrpt_result_checker #(
  parameter int NUM_BASES = mrpt_pkg::NumBasesDefault
) (
  input logic clk,
  input logic rst_n,
  mrpt_in_if in_ch,
  mrpt_out_if out_ch,
  output int mismatches,
  output int verdicts_due,
  output int primes_seen
);

  localparam longint unsigned Witness[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

  logic verdict_q[$];

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned g, longint unsigned k,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    while (k != 0) begin
      if (k[0]) acc = mul_mod(acc, g, m);
      g = mul_mod(g, g, m);
      k = k >> 1;
    end
    return acc;
  endfunction

  // Strong probable-prime test against the first bases; exact for 63 bits.
  function automatic logic primality(mrpt_pkg::num_t number);
    longint unsigned n, d, x, y;
    int nb, s;
    n = {1'b0, number};
    nb = (NUM_BASES > 12) ? 12 : NUM_BASES;
    if (n < 2) return 1'b0;
    for (int i = 0; i < nb; i++)
      if (n == Witness[i]) return 1'b1;
    d = n - 1;
    s = 0;
    while (!d[0] && s < 63) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < nb; i++) begin
      x = pow_mod(Witness[i] % n, d, n);
      y = x;
      for (int j = 0; j < s; j++) begin
        y = mul_mod(x, x, n);
        if (y == 1 && x != 1 && x != n - 1) return 1'b0;
        x = y;
      end
      if (y != 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    mismatches = 0;
    primes_seen = 0;
    verdicts_due = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_q.push_back(primality(in_ch.number));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with no request pending: actual is_prime=%0b",
                   $time, out_ch.is_prime);
          mismatches++;
        end else begin
          logic want;
          want = verdict_q.pop_front();
          if (want) primes_seen++;
          if (out_ch.is_prime !== want) begin
            $display("%0t: is_prime mismatch: expected %0b, actual %0b",
                     $time, want, out_ch.is_prime);
            mismatches++;
          end
        end
      end
      verdicts_due <= verdict_q.size();
    end
  end

endmodule

/* tb/sv/miller_rabin_prime_test_tb.sv */
`timescale 1ns / 100ps

module miller_rabin_prime_test_tb;

  // Even if every number were as slow as a large prime and every result stalled,
  // this bound stays a few times above the run.
  localparam int CycleLimit = 30000000;
  localparam longint unsigned NumMask = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;
  int mismatches;
  int verdicts_due;
  int primes_seen;
  int cycles = 0;
  int sent;
  bit quiet;   // when set, neither side idles
  int stall;

  mrpt_in_if in_ch ();
  mrpt_out_if out_ch ();

  miller_rabin_prime_test dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  mrpt_result_checker chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .mismatches(mismatches),
    .verdicts_due(verdicts_due),
    .primes_seen(primes_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The watchdog ends a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls for a random number of cycles after each result it
  // takes, unless the quiet stretch is on.
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      stall <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = quiet ? 0 : $urandom_range(0, 11);
      stall <= w;
      out_ch.ready <= (w == 0);
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= (stall == 1);
    end
  end

  // Sends one request. The valid line is lowered only for a real gap, so a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic send_number(longint unsigned value);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.number <= mrpt_pkg::num_t'(value & NumMask);
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // The checker's count is registered and takes its new value at the accepting
  // edge, so look only after that edge has passed.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
  endtask

  initial begin
    longint unsigned v;
    sent = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.number = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: zero and one, the bases themselves, primes just past
    // the bases, small evens and composites, strong pseudoprimes that fool
    // the first bases, and the extremes of the 63-bit range.
    send_number(0);
    send_number(1);
    send_number(2);
    send_number(3);
    send_number(4);
    send_number(29);
    send_number(31);
    send_number(37);
    send_number(9);
    send_number(561);
    send_number(2047);
    send_number(1373653);
    send_number(3215031751);
    send_number(64'd9223372036854775783);   // largest 63-bit prime
    send_number(64'h7FFF_FFFF_FFFF_FFFF);
    send_number(64'h7FFF_FFFF_FFFF_FFFE);
    send_number(64'h4000_0000_0000_0000);
    send_number(64'd3825123056546413051);   // passes every base up to 23

    // Hold off until the block has returned every result.
    drain();

    for (int i = 0; i < 85; i++) begin
      quiet = (i >= 40 && i < 55);
      case ($urandom_range(0, 9))
        0, 1, 2: v = {$urandom, $urandom};
        3: v = $urandom_range(2, 40);
        default: v = $urandom_range(2, 16383) | 1;
      endcase
      send_number(v);
    end
    quiet = 1'b0;

    drain();
    repeat (200) @(posedge clk);

    $display("Checked %0d numbers (%0d found prime), from the edge cases through", sent,
             primes_seen);
    $display("random small and full-width values under random stalls on both sides.");
    if (mismatches == 0 && verdicts_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
